[rtl/tmtw_pkg.sv]
package tmtw_pkg;

  // Default screen geometry
  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  // Port widths
  localparam int OP_W       = 1;
  localparam int CHAR_W     = 8;
  localparam int IDX_W      = 11;
  localparam int WORD_W     = 16;
  localparam int COL_W      = 7;
  localparam int ROW_W      = 5;
  localparam int ADDR_W     = 11;
  localparam int ATTR_W     = 8;
  localparam int TAB_W      = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  // Operations
  localparam logic [OP_W-1:0] OP_WRITE = 1'b0;
  localparam logic [OP_W-1:0] OP_READ  = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_ATTR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TAB_WIDTH = 1'b1;

  // Reset values
  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;
  localparam logic [TAB_W-1:0]  TAB_RESET  = 7'd8;
  localparam logic [WORD_W-1:0] RESET_CELL = 16'h0720;
  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;

  // Control codes
  localparam logic [CHAR_W-1:0] CH_BEL = 8'h07;
  localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_VT  = 8'h0B;
  localparam logic [CHAR_W-1:0] CH_FF  = 8'h0C;
  localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_ESC = 8'h1B;

  typedef enum logic [2:0] {
    CC_IGNORE,
    CC_BS,
    CC_DOWN,
    CC_NL,
    CC_CR,
    CC_TAB,
    CC_PRINT
  } char_class_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRCH,
    ST_FILL_NL,
    ST_TAB_MOD,
    ST_FILL_TAB,
    ST_BLANK,
    ST_SCR_RD,
    ST_SCR_WR,
    ST_CHK,
    ST_RD,
    ST_RESP
  } state_t;

  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_BS,
    CUR_DOWN,
    CUR_CR,
    CUR_RIGHT,
    CUR_WRAP,
    CUR_SCROLL
  } cur_cmd_t;

  typedef enum logic [1:0] {
    WS_CHAR,
    WS_BLANK,
    WS_RESET,
    WS_COPY
  } wsrc_t;

  typedef struct packed {
    logic     accept;
    cur_cmd_t cur;
    logic     wr_en;
    wsrc_t    wsrc;
    logic     wsel_ptr;
    logic     rd_en;
    logic     rsel_scroll;
    logic     ptr_inc;
    logic     rem_sub;
    logic     pad_load;
    logic     pad_dec;
    logic     word_load;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic copy_done;
    logic row_end;
    logic col_full;
    logic last_col;
    logic row_full;
    logic rem_ge;
    logic pad_last;
    logic out_busy;
  } dp_status_t;

  function automatic char_class_t char_class(input logic [CHAR_W-1:0] ch);
    char_class_t cc;
    cc = CC_PRINT;
    if (ch == CH_BEL || ch == CH_ESC) cc = CC_IGNORE;
    else if (ch == CH_BS)             cc = CC_BS;
    else if (ch == CH_VT || ch == CH_FF) cc = CC_DOWN;
    else if (ch == CH_LF)             cc = CC_NL;
    else if (ch == CH_CR)             cc = CC_CR;
    else if (ch == CH_TAB)            cc = CC_TAB;
    return cc;
  endfunction

endpackage

[rtl/text_mode_terminal_writer.sv]
// A scroll adds a read/write copy loop on the one RAM.
// One transaction in flight; the next is taken once the result is in the output register.
// Reset (rst_n low, synchronous) clears the cursor and resets the registers, then a clearing pass
//   writes 0x0720 to all COLUMNS*ROWS cells with in_ready low.
module text_mode_terminal_writer #(
  parameter int COLUMNS = tmtw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tmtw_pkg::DEF_ROWS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [tmtw_pkg::OP_W-1:0]           in_operation,
  input  logic [tmtw_pkg::CHAR_W-1:0]         in_char_code,
  input  logic [tmtw_pkg::IDX_W-1:0]          in_cell_index,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [tmtw_pkg::WORD_W-1:0]         out_cell_word,
  output logic [tmtw_pkg::COL_W-1:0]          out_cursor_col,
  output logic [tmtw_pkg::ROW_W-1:0]          out_cursor_row,
  output logic [tmtw_pkg::ADDR_W-1:0]         out_cursor_address,
  // configuration writes
  input  logic                                cfg_we,
  input  logic [tmtw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tmtw_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // The controller sequences one transaction through the datapath:
  //  - printable char: one cell write at the cursor, step right
  //  - newline / tab: one blank per cycle; tab first reduces the column
  //    modulo tab width by repeated subtraction, then pads to the stop
  //  - carriage return: sweep the cursor row with blanks
  //  - after any write op, a check state wraps the column, then scrolls
  //    (copy row r+1 to row r cell by cell, then blank the bottom row)
  // The result sits in an output register, so the next input can be taken
  // while the previous result waits for out_ready.

  tmtw_pkg::dp_cmd_t    cmd;
  tmtw_pkg::dp_status_t status;

  tmtw_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_char_code (in_char_code),
    .status       (status),
    .cmd          (cmd)
  );

  tmtw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .in_char_code       (in_char_code),
    .in_cell_index      (in_cell_index),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_cell_word      (out_cell_word),
    .out_cursor_col     (out_cursor_col),
    .out_cursor_row     (out_cursor_row),
    .out_cursor_address (out_cursor_address)
  );

endmodule

[rtl/tmtw_ram.sv]
module tmtw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/tmtw_ctrl.sv]
module tmtw_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [tmtw_pkg::OP_W-1:0]        in_operation,
  input  logic [tmtw_pkg::CHAR_W-1:0]      in_char_code,
  input  tmtw_pkg::dp_status_t             status,
  output tmtw_pkg::dp_cmd_t                cmd
);

  tmtw_pkg::state_t      state_r, state_nxt;
  tmtw_pkg::char_class_t cls;
  logic                  accept;

  assign cls    = tmtw_pkg::char_class(in_char_code);
  assign accept = in_valid && (state_r == tmtw_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tmtw_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tmtw_pkg::ST_CLEAR: begin
        if (status.clear_done) state_nxt = tmtw_pkg::ST_IDLE;
      end
      tmtw_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_operation == tmtw_pkg::OP_READ) begin
            state_nxt = tmtw_pkg::ST_RD;
          end else begin
            unique case (cls)
              tmtw_pkg::CC_IGNORE,
              tmtw_pkg::CC_BS,
              tmtw_pkg::CC_DOWN:  state_nxt = tmtw_pkg::ST_CHK;
              tmtw_pkg::CC_CR:    state_nxt = tmtw_pkg::ST_BLANK;
              tmtw_pkg::CC_NL:    state_nxt = tmtw_pkg::ST_FILL_NL;
              tmtw_pkg::CC_TAB:   state_nxt = tmtw_pkg::ST_TAB_MOD;
              tmtw_pkg::CC_PRINT: state_nxt = tmtw_pkg::ST_WRCH;
              default:            state_nxt = tmtw_pkg::ST_CHK;
            endcase
          end
        end
      end
      tmtw_pkg::ST_WRCH: state_nxt = tmtw_pkg::ST_CHK;
      tmtw_pkg::ST_FILL_NL: begin
        if (status.last_col) state_nxt = tmtw_pkg::ST_CHK;
      end
      tmtw_pkg::ST_TAB_MOD: begin
        if (!status.rem_ge) state_nxt = tmtw_pkg::ST_FILL_TAB;
      end
      tmtw_pkg::ST_FILL_TAB: begin
        if (status.pad_last || status.last_col) state_nxt = tmtw_pkg::ST_CHK;
      end
      tmtw_pkg::ST_BLANK: begin
        if (status.row_end) state_nxt = tmtw_pkg::ST_CHK;
      end
      tmtw_pkg::ST_SCR_RD: state_nxt = tmtw_pkg::ST_SCR_WR;
      tmtw_pkg::ST_SCR_WR: begin
        state_nxt = status.copy_done ? tmtw_pkg::ST_BLANK : tmtw_pkg::ST_SCR_RD;
      end
      tmtw_pkg::ST_CHK: begin
        priority if (status.col_full) state_nxt = tmtw_pkg::ST_CHK;
        else if (status.row_full)     state_nxt = tmtw_pkg::ST_SCR_RD;
        else                          state_nxt = tmtw_pkg::ST_RESP;
      end
      tmtw_pkg::ST_RD: state_nxt = tmtw_pkg::ST_RESP;
      tmtw_pkg::ST_RESP: begin
        if (!status.out_busy) state_nxt = tmtw_pkg::ST_IDLE;
      end
      default: state_nxt = tmtw_pkg::ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    cmd.cur  = tmtw_pkg::CUR_HOLD;
    cmd.wsrc = tmtw_pkg::WS_BLANK;
    in_ready = 1'b0;
    unique case (state_r)
      tmtw_pkg::ST_CLEAR: begin
        cmd.wr_en    = 1'b1;
        cmd.wsrc     = tmtw_pkg::WS_RESET;
        cmd.wsel_ptr = 1'b1;
        cmd.ptr_inc  = 1'b1;
      end
      tmtw_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          cmd.accept = 1'b1;
          if (in_operation == tmtw_pkg::OP_READ) begin
            cmd.rd_en = 1'b1;
          end else begin
            unique case (cls)
              tmtw_pkg::CC_BS:   cmd.cur = tmtw_pkg::CUR_BS;
              tmtw_pkg::CC_DOWN: cmd.cur = tmtw_pkg::CUR_DOWN;
              tmtw_pkg::CC_CR:   cmd.cur = tmtw_pkg::CUR_CR;
              default:           cmd.cur = tmtw_pkg::CUR_HOLD;
            endcase
          end
        end
      end
      tmtw_pkg::ST_WRCH: begin
        cmd.wr_en = 1'b1;
        cmd.wsrc  = tmtw_pkg::WS_CHAR;
        cmd.cur   = tmtw_pkg::CUR_RIGHT;
      end
      tmtw_pkg::ST_FILL_NL: begin
        cmd.wr_en = 1'b1;
        cmd.cur   = tmtw_pkg::CUR_RIGHT;
      end
      tmtw_pkg::ST_TAB_MOD: begin
        if (status.rem_ge) cmd.rem_sub = 1'b1;
        else               cmd.pad_load = 1'b1;
      end
      tmtw_pkg::ST_FILL_TAB: begin
        cmd.wr_en   = 1'b1;
        cmd.cur     = tmtw_pkg::CUR_RIGHT;
        cmd.pad_dec = 1'b1;
      end
      tmtw_pkg::ST_BLANK: begin
        cmd.wr_en    = 1'b1;
        cmd.wsel_ptr = 1'b1;
        cmd.ptr_inc  = 1'b1;
      end
      tmtw_pkg::ST_SCR_RD: begin
        cmd.rd_en       = 1'b1;
        cmd.rsel_scroll = 1'b1;
      end
      tmtw_pkg::ST_SCR_WR: begin
        cmd.wr_en    = 1'b1;
        cmd.wsrc     = tmtw_pkg::WS_COPY;
        cmd.wsel_ptr = 1'b1;
        cmd.ptr_inc  = 1'b1;
      end
      tmtw_pkg::ST_CHK: begin
        priority if (status.col_full) cmd.cur = tmtw_pkg::CUR_WRAP;
        else if (status.row_full)     cmd.cur = tmtw_pkg::CUR_SCROLL;
        else                          cmd.cur = tmtw_pkg::CUR_HOLD;
      end
      tmtw_pkg::ST_RD: begin
        cmd.word_load = 1'b1;
      end
      tmtw_pkg::ST_RESP: begin
        cmd.out_load = !status.out_busy;
      end
      default: begin
        cmd.cur = tmtw_pkg::CUR_HOLD;
      end
    endcase
  end

endmodule

[rtl/tmtw_datapath.sv]
module tmtw_datapath #(
  parameter int COLUMNS = tmtw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tmtw_pkg::DEF_ROWS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tmtw_pkg::dp_cmd_t                   cmd,
  output tmtw_pkg::dp_status_t                status,
  input  logic [tmtw_pkg::CHAR_W-1:0]         in_char_code,
  input  logic [tmtw_pkg::IDX_W-1:0]          in_cell_index,
  input  logic                                cfg_we,
  input  logic [tmtw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tmtw_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [tmtw_pkg::WORD_W-1:0]         out_cell_word,
  output logic [tmtw_pkg::COL_W-1:0]          out_cursor_col,
  output logic [tmtw_pkg::ROW_W-1:0]          out_cursor_row,
  output logic [tmtw_pkg::ADDR_W-1:0]         out_cursor_address
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CAW   = $clog2(CELLS + COLUMNS);
  localparam int CW    = $clog2(COLUMNS + 1);
  localparam int RW    = $clog2(ROWS + 1);
  localparam int TW    = tmtw_pkg::TAB_W;
  localparam int MW    = (CW > TW) ? CW : TW;

  // cursor (column may reach COLUMNS and row ROWS before wrap/scroll)
  logic [CW-1:0]  col_r, col_nxt;
  logic [RW-1:0]  row_r, row_nxt;
  logic [CAW-1:0] caddr_r, caddr_nxt;
  logic [AW-1:0]  ptr_r, ptr_nxt;

  logic [tmtw_pkg::ATTR_W-1:0] attr_r;
  logic [TW-1:0]               tab_r;
  logic                        out_valid_r;

  logic [tmtw_pkg::CHAR_W-1:0] ch_r;
  logic [MW-1:0]               rem_r;
  logic [TW-1:0]               pad_r;
  logic                        idx_ok_r;
  logic [tmtw_pkg::WORD_W-1:0] word_r;

  logic [tmtw_pkg::WORD_W-1:0] out_word_r;
  logic [tmtw_pkg::COL_W-1:0]  out_col_r;
  logic [tmtw_pkg::ROW_W-1:0]  out_row_r;
  logic [tmtw_pkg::ADDR_W-1:0] out_addr_r;

  logic [TW-1:0]               tw_eff;
  logic [MW-1:0]               tw_ext;
  logic [CAW-1:0]              row_start;
  logic [31:0]                 idx_ext, col_ext, row_ext, caddr_ext;

  logic                        ram_we, ram_re;
  logic [AW-1:0]               ram_waddr, ram_raddr;
  logic [tmtw_pkg::WORD_W-1:0] ram_wdata, ram_rdata;

  assign tw_eff    = (tab_r == '0) ? TW'(1) : tab_r;
  assign tw_ext    = MW'(tw_eff);
  assign row_start = caddr_r - CAW'(col_r);
  assign idx_ext   = 32'(in_cell_index);
  assign col_ext   = 32'(col_r);
  assign row_ext   = 32'(row_r);
  assign caddr_ext = 32'(caddr_r);

  // cursor / sweep pointer update
  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    caddr_nxt = caddr_r;
    ptr_nxt   = ptr_r;
    unique case (cmd.cur)
      tmtw_pkg::CUR_HOLD: ;
      tmtw_pkg::CUR_BS: begin
        if (col_r == '0) begin
          if (row_r != '0) begin
            col_nxt   = CW'(COLUMNS - 1);
            row_nxt   = row_r - RW'(1);
            caddr_nxt = caddr_r - CAW'(1);
          end
        end else begin
          col_nxt   = col_r - CW'(1);
          caddr_nxt = caddr_r - CAW'(1);
        end
      end
      tmtw_pkg::CUR_DOWN: begin
        row_nxt   = row_r + RW'(1);
        caddr_nxt = caddr_r + CAW'(COLUMNS);
      end
      tmtw_pkg::CUR_CR: begin
        col_nxt   = '0;
        caddr_nxt = row_start;
        ptr_nxt   = row_start[AW-1:0];
      end
      tmtw_pkg::CUR_RIGHT: begin
        col_nxt   = col_r + CW'(1);
        caddr_nxt = caddr_r + CAW'(1);
      end
      tmtw_pkg::CUR_WRAP: begin
        // linear address of column COLUMNS equals start of next row
        col_nxt = '0;
        row_nxt = row_r + RW'(1);
      end
      tmtw_pkg::CUR_SCROLL: begin
        col_nxt   = '0;
        row_nxt   = RW'(ROWS - 1);
        caddr_nxt = CAW'(CELLS - COLUMNS);
        ptr_nxt   = '0;
      end
      default: ;
    endcase
    if (cmd.ptr_inc) ptr_nxt = ptr_r + AW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      caddr_r     <= '0;
      ptr_r       <= '0;
      attr_r      <= tmtw_pkg::ATTR_RESET;
      tab_r       <= tmtw_pkg::TAB_RESET;
      out_valid_r <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      caddr_r     <= caddr_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= cmd.out_load || (out_valid_r && !out_ready);
      if (cfg_we) begin
        unique case (cfg_index)
          tmtw_pkg::REG_TEXT_ATTR: attr_r <= cfg_data[tmtw_pkg::ATTR_W-1:0];
          tmtw_pkg::REG_TAB_WIDTH: tab_r  <= cfg_data[TW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ch_r     <= in_char_code;
      rem_r    <= MW'(col_r);
      idx_ok_r <= idx_ext < 32'(CELLS);
      word_r   <= '0;
    end
    if (cmd.rem_sub)   rem_r  <= rem_r - tw_ext;
    if (cmd.pad_load)  pad_r  <= TW'(tw_ext - rem_r);
    if (cmd.pad_dec)   pad_r  <= pad_r - TW'(1);
    if (cmd.word_load) word_r <= idx_ok_r ? ram_rdata : '0;
    if (cmd.out_load) begin
      out_word_r <= word_r;
      out_col_r  <= col_ext[tmtw_pkg::COL_W-1:0];
      out_row_r  <= row_ext[tmtw_pkg::ROW_W-1:0];
      out_addr_r <= caddr_ext[tmtw_pkg::ADDR_W-1:0];
    end
  end

  // screen memory
  always_comb begin
    unique case (cmd.wsrc)
      tmtw_pkg::WS_CHAR:  ram_wdata = {attr_r, ch_r};
      tmtw_pkg::WS_BLANK: ram_wdata = {attr_r, tmtw_pkg::BLANK_CHAR};
      tmtw_pkg::WS_RESET: ram_wdata = tmtw_pkg::RESET_CELL;
      tmtw_pkg::WS_COPY:  ram_wdata = ram_rdata;
      default:            ram_wdata = tmtw_pkg::RESET_CELL;
    endcase
  end

  assign ram_we    = cmd.wr_en;
  assign ram_re    = cmd.rd_en;
  assign ram_waddr = cmd.wsel_ptr ? ptr_r : caddr_r[AW-1:0];
  assign ram_raddr = cmd.rsel_scroll ? (ptr_r + AW'(COLUMNS)) : idx_ext[AW-1:0];

  tmtw_ram #(
    .WIDTH (tmtw_pkg::WORD_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // status
  assign status.clear_done = (ptr_r == AW'(CELLS - 1));
  assign status.copy_done  = (ptr_r == AW'(CELLS - COLUMNS - 1));
  assign status.row_end    = (CAW'(ptr_r) == caddr_r + CAW'(COLUMNS - 1));
  assign status.col_full   = (col_r == CW'(COLUMNS));
  assign status.last_col   = (col_r == CW'(COLUMNS - 1));
  assign status.row_full   = (row_r == RW'(ROWS));
  assign status.rem_ge     = (rem_r >= tw_ext);
  assign status.pad_last   = (pad_r == TW'(1));
  assign status.out_busy   = out_valid_r && !out_ready;

  assign out_valid          = out_valid_r;
  assign out_cell_word      = out_word_r;
  assign out_cursor_col     = out_col_r;
  assign out_cursor_row     = out_row_r;
  assign out_cursor_address = out_addr_r;

endmodule
